// ===== rtl/mhid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhid_pkg
// Shared types, codes and constants of the binary max heap block.
// ----------------------------------------------------------------------------
package mhid_pkg;

   localparam int DATA_W          = 32;
   localparam int MAX_ENTRIES_DEF = 64;
   localparam int RESULT_LIMIT    = 64;
   localparam int CAP_W           = 7;
   localparam int ACTION_W        = 2;
   localparam int STATUS_W        = 2;
   localparam int COUNT_OUT_W     = 7;
   localparam int INDEX_OUT_W     = 6;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_BUILD,
      ST_RD_NODE,
      ST_RD_LEFT,
      ST_CMP_LEFT,
      ST_CMP_RIGHT,
      ST_SWAP_HI,
      ST_SWAP_LO,
      ST_ROOT,
      ST_RESP,
      ST_DUMP_RD,
      ST_DUMP_OUT
   } state_type;

endpackage

// ===== rtl/mhid_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhid_ram
// Heap storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mhid_ram #(
   parameter int DEPTH  = mhid_pkg::MAX_ENTRIES_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [mhid_pkg::DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [mhid_pkg::DATA_W-1:0] rd_data
);
   import mhid_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/max_heap_insert_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_insert_delete
// Array-based binary max heap of signed 32-bit values with insert, delete of
// the first match and dump, rebuilt bottom-up after every change.
// ----------------------------------------------------------------------------
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+---------------
//  req     | req_action, req_value                         | valid / stall
//  rsp     | rsp_status, rsp_entry_count, rsp_entry_index, | valid / stall
//          | rsp_entry_value, rsp_last                     |
//  csr     | csr_capacity_limit                            | valid / ready
//
//  One request at a time; req_stall is high until its last response is loaded.
//  Insert/delete: a delete scans the entries for a match, then moves the last
//  entry into its place; then the rebuild visits every parent and sinks it
//  level by level. Dump: one entry read at a time. The single read port of the
//  heap memory, with registered read data, sets the pace of these steps.
//  Synchronous reset empties the heap and sets the capacity limit to 64.
//  A stalled response holds the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module max_heap_insert_delete #(
   parameter int MAX_ENTRIES = mhid_pkg::MAX_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mhid_pkg::ACTION_W-1:0]    req_action,
   input  logic [mhid_pkg::DATA_W-1:0]      req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mhid_pkg::STATUS_W-1:0]    rsp_status,
   output logic [mhid_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [mhid_pkg::INDEX_OUT_W-1:0] rsp_entry_index,
   output logic [mhid_pkg::DATA_W-1:0]      rsp_entry_value,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mhid_pkg::CAP_W-1:0]       csr_capacity_limit
);
   import mhid_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      parent_ff, parent_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [IDX_W-1:0]      node_ff, node_in;
   logic [IDX_W-1:0]      top_ff, top_in;
   logic [IDX_W-1:0]      at_ff, at_in;
   logic [DATA_W-1:0]     value_ff, value_in;
   logic [DATA_W-1:0]     top_val_ff, top_val_in;
   logic [DATA_W-1:0]     node_val_ff, node_val_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [INDEX_OUT_W-1:0] rsp_index_ff, rsp_index_in;
   logic [DATA_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [DATA_W-1:0]     mem_wdata;
   logic [IDX_W-1:0]      mem_raddr;
   logic [DATA_W-1:0]     mem_rdata;

   logic                  req_take;
   logic                  rsp_free;
   logic                  heap_full;
   logic                  child_gt;
   logic                  scan_hit;
   logic                  dump_last;
   logic                  l_in_range;
   logic                  r_in_range;
   logic [CNT_W:0]        count_nx;
   logic [CNT_W-1:0]      count_dec;
   logic [CNT_W:0]        scan_nx;
   logic [IDX_W:0]        child_l;
   logic [IDX_W:0]        child_r;
   logic [COUNT_OUT_W+CNT_W-1:0] count_wide;
   logic [INDEX_OUT_W+CNT_W-1:0] scan_wide;
   logic [DATA_W-1:0]     root_value;

   mhid_ram #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign count_nx   = {1'b0, count_ff} + (CNT_W+1)'(1);
   assign count_dec  = count_ff - CNT_W'(1);
   assign scan_nx    = {1'b0, scan_ff} + (CNT_W+1)'(1);
   assign child_l    = {node_ff, 1'b1};
   assign child_r    = {node_ff, 1'b0} + (IDX_W+1)'(2);
   assign l_in_range = 32'(child_l) < 32'(count_ff);
   assign r_in_range = 32'(child_r) < 32'(count_ff);
   assign heap_full  = (32'(count_ff) >= 32'(cap_ff)) || (32'(count_ff) >= MAX_ENTRIES);
   assign dump_last  = (32'(scan_nx) == 32'(count_ff)) || (32'(scan_nx) == RESULT_LIMIT);
   assign count_wide = {COUNT_OUT_W'(0), count_ff};
   assign scan_wide  = {INDEX_OUT_W'(0), scan_ff};
   assign root_value = (count_ff != '0) ? mem_rdata : '0;

   // compare units: read word against current top (shared by both children) or search key
   assign child_gt = $signed(mem_rdata) > $signed(top_val_ff);
   assign scan_hit = (mem_rdata == value_ff);

   // next parent to sift, counting down from count/2-1
   function automatic logic [IDX_W-1:0] count_dec_parent(input logic [CNT_W-1:0] p);
      logic [CNT_W-1:0] d;
      d = p - CNT_W'(1);
      return d[IDX_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      parent_ff     <= parent_in;
      scan_ff       <= scan_in;
      node_ff       <= node_in;
      top_ff        <= top_in;
      at_ff         <= at_in;
      value_ff      <= value_in;
      top_val_ff    <= top_val_in;
      node_val_ff   <= node_val_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      parent_in     = parent_ff;
      scan_in       = scan_ff;
      node_in       = node_ff;
      top_in        = top_ff;
      at_in         = at_ff;
      value_in      = value_ff;
      top_val_in    = top_val_ff;
      node_val_in   = node_val_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = node_ff;
      mem_wdata     = top_val_ff;
      mem_raddr     = '0;

      if (csr_valid && csr_ready) begin
         cap_in = csr_capacity_limit;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               value_in  = req_value;
               status_in = STATUS_OK;
               scan_in   = '0;
               case (req_action)
                  ACT_INSERT: begin
                     if (heap_full) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_ROOT;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[IDX_W-1:0];
                        mem_wdata = req_value;
                        count_in  = count_nx[CNT_W-1:0];
                        parent_in = count_nx[CNT_W:1];
                        state_in  = ST_BUILD;
                     end
                  end
                  ACT_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_NOT_FOUND;
                        state_in  = ST_ROOT;
                     end else begin
                        state_in  = ST_SCAN_RD;
                     end
                  end
                  ACT_DUMP: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_RESP;
                     end else begin
                        state_in  = ST_DUMP_RD;
                     end
                  end
                  default: begin
                     state_in = ST_ROOT;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            mem_raddr = scan_ff[IDX_W-1:0];
            state_in  = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (scan_hit) begin
               at_in    = scan_ff[IDX_W-1:0];
               state_in = ST_MOVE_RD;
            end else if (32'(scan_nx) == 32'(count_ff)) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_ROOT;
            end else begin
               scan_in  = scan_nx[CNT_W-1:0];
               state_in = ST_SCAN_RD;
            end
         end
         ST_MOVE_RD: begin
            mem_raddr = count_dec[IDX_W-1:0];
            state_in  = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            // last entry fills the hole left by the deleted one
            mem_we    = 1'b1;
            mem_waddr = at_ff;
            mem_wdata = mem_rdata;
            count_in  = count_dec;
            parent_in = count_dec >> 1;
            state_in  = ST_BUILD;
         end
         ST_BUILD: begin
            if (parent_ff == '0) begin
               state_in = ST_ROOT;
            end else begin
               node_in   = count_dec_parent(parent_ff);
               parent_in = parent_ff - CNT_W'(1);
               state_in  = ST_RD_NODE;
            end
         end
         ST_RD_NODE: begin
            mem_raddr = node_ff;
            state_in  = ST_RD_LEFT;
         end
         ST_RD_LEFT: begin
            node_val_in = mem_rdata;
            top_val_in  = mem_rdata;
            top_in      = node_ff;
            if (l_in_range) begin
               mem_raddr = child_l[IDX_W-1:0];
               state_in  = ST_CMP_LEFT;
            end else begin
               state_in  = ST_BUILD;
            end
         end
         ST_CMP_LEFT: begin
            if (child_gt) begin
               top_in     = child_l[IDX_W-1:0];
               top_val_in = mem_rdata;
            end
            if (r_in_range) begin
               mem_raddr = child_r[IDX_W-1:0];
               state_in  = ST_CMP_RIGHT;
            end else begin
               state_in  = ST_SWAP_HI;
            end
         end
         ST_CMP_RIGHT: begin
            // strict compare keeps the left child on a tie
            if (child_gt) begin
               top_in     = child_r[IDX_W-1:0];
               top_val_in = mem_rdata;
            end
            state_in = ST_SWAP_HI;
         end
         ST_SWAP_HI: begin
            if (top_ff == node_ff) begin
               state_in = ST_BUILD;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = node_ff;
               mem_wdata = top_val_ff;
               state_in  = ST_SWAP_LO;
            end
         end
         ST_SWAP_LO: begin
            mem_we    = 1'b1;
            mem_waddr = top_ff;
            mem_wdata = node_val_ff;
            node_in   = top_ff;
            state_in  = ST_RD_NODE;
         end
         ST_ROOT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_wide[COUNT_OUT_W-1:0];
               rsp_index_in  = '0;
               rsp_value_in  = root_value;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            mem_raddr = scan_ff[IDX_W-1:0];
            state_in  = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            mem_raddr = scan_ff[IDX_W-1:0];
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_count_in  = count_wide[COUNT_OUT_W-1:0];
               rsp_index_in  = scan_wide[INDEX_OUT_W-1:0];
               rsp_value_in  = mem_rdata;
               rsp_last_in   = dump_last;
               scan_in       = scan_nx[CNT_W-1:0];
               state_in      = dump_last ? ST_IDLE : ST_DUMP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_ENTRIES)
      else $error("heap count beyond capacity");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1)) ||
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("heap count moved by more than one");

   a_idle_write : assert property (@(posedge clock) disable iff (reset)
      mem_we && (state_ff == ST_IDLE) |-> req_take && (req_action == ACT_INSERT))
      else $error("heap written while idle without an insert transaction");

endmodule
